### rtl/core/slxfp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// slxfp_pkg
// Shared types and constants of the sync/length/XOR frame parser.
// ----------------------------------------------------------------------------
package slxfp_pkg;

    localparam logic [7:0]  SYNC_BYTE      = 8'hF0;
    localparam logic [7:0]  TYPE_SELFCHECK = 8'h02;
    localparam logic [7:0]  TYPE_PULSE     = 8'h04;
    localparam logic [7:0]  TYPE_BEAM      = 8'h06;
    localparam logic [15:0] FIRST_CAPTURED = 16'd5;
    localparam logic [15:0] MIN_LENGTH     = 16'd6;
    localparam logic [15:0] LEN_SELFCHECK  = 16'd8;
    localparam logic [15:0] LEN_PULSE      = 16'd15;
    localparam logic [15:0] LEN_BEAM       = 16'd13;
    localparam logic [1:0]  FLAG_CHAN_ONE  = 2'b01;
    localparam logic [1:0]  FLAG_CHAN_TWO  = 2'b10;
    localparam logic [1:0]  FLAG_CHAN_THR  = 2'b11;

    // captured bytes handed from the parser to the formatter
    localparam int REC_BYTES = 8;

    typedef enum logic [1:0] {
        KIND_SELFCHECK = 2'd0,
        KIND_PULSE     = 2'd1,
        KIND_BEAM      = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind                          kind;
        logic [REC_BYTES-1:0][7:0]      bytes;
    } t_rec;

endpackage
`default_nettype wire

### rtl/core/sync_length_xor_frame_parser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sync_length_xor_frame_parser
// Deframes a received byte stream (sync F0 F0, type, 16-bit LE length, body,
// XOR checksum) and emits one decoded result per valid known frame.
//
// Input channel: one received byte per item on i_rx_byte, i_valid/o_ready.
// Output channel: one result per accepted frame, o_valid/i_ready, with every
// field not belonging to the frame kind driven to zero.
// Throughput: one byte per cycle; o_ready drops only when the two-entry
// result queue is full.
// Result path: the frame's record is written into the queue when its last
// byte is accepted, then moved from the queue into the output register
// once that register is empty or its result is being taken.
// Reset: parser returns to sync hunt, queue and output register empty.
// Receiver stall: the output register holds its result, the queue absorbs
// up to two more results; byte intake stops once the queue is full.
// ----------------------------------------------------------------------------
module sync_length_xor_frame_parser
    import slxfp_pkg::*;
#(
    parameter int CAPTURE_BYTES = 10
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [7:0]  i_rx_byte,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [1:0]       o_frame_kind,
    output logic [7:0]       o_status_first,
    output logic [7:0]       o_status_second,
    output logic [7:0]       o_status_third,
    output logic             o_chan_one_active,
    output logic             o_chan_two_active,
    output logic             o_chan_three_active,
    output logic [15:0]      o_pulse_parameter,
    output logic [7:0]       o_pulse_channel_byte,
    output logic [7:0]       o_peak_frequency,
    output logic [31:0]      o_beam_params_low,
    output logic [15:0]      o_beam_param_third
);

    logic q_full, q_empty, push, pop;
    t_rec rec_in, rec_out;

    slxfp_front #(
        .CAPTURE_BYTES (CAPTURE_BYTES)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_rx_byte (i_rx_byte),
        .i_q_full  (q_full),
        .o_push    (push),
        .o_rec     (rec_in)
    );

    slxfp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_rec   (rec_in),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_empty (q_empty),
        .o_rec   (rec_out)
    );

    slxfp_back u_back (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_q_empty            (q_empty),
        .i_rec                (rec_out),
        .o_pop                (pop),
        .o_valid              (o_valid),
        .i_ready              (i_ready),
        .o_frame_kind         (o_frame_kind),
        .o_status_first       (o_status_first),
        .o_status_second      (o_status_second),
        .o_status_third       (o_status_third),
        .o_chan_one_active    (o_chan_one_active),
        .o_chan_two_active    (o_chan_two_active),
        .o_chan_three_active  (o_chan_three_active),
        .o_pulse_parameter    (o_pulse_parameter),
        .o_pulse_channel_byte (o_pulse_channel_byte),
        .o_peak_frequency     (o_peak_frequency),
        .o_beam_params_low    (o_beam_params_low),
        .o_beam_param_third   (o_beam_param_third)
    );

endmodule
`default_nettype wire

### rtl/core/slxfp_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// slxfp_front
// Frame parser: sync hunt, header decode, running XOR, body capture and
// frame-end classification into a result record.
// ----------------------------------------------------------------------------
module slxfp_front
    import slxfp_pkg::*;
#(
    parameter int CAPTURE_BYTES = 10
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [7:0] i_rx_byte,
    input  wire logic       i_q_full,
    output logic            o_push,
    output t_rec            o_rec
);

    typedef enum logic [5:0] {
        PH_HUNT1  = 6'b000001,
        PH_HUNT2  = 6'b000010,
        PH_TYPE   = 6'b000100,
        PH_LEN_LO = 6'b001000,
        PH_LEN_HI = 6'b010000,
        PH_BODY   = 6'b100000
    } t_phase;

    t_phase                           r_phase, n_phase;
    logic [7:0]                       r_type, n_type;
    logic [15:0]                      r_len, n_len;
    logic [15:0]                      r_pos, n_pos;
    logic [7:0]                       r_xor, n_xor;
    logic [CAPTURE_BYTES-1:0][7:0]    r_cap;
    logic [CAPTURE_BYTES-1:0][7:0]    cap_next;
    logic [CAPTURE_BYTES-1:0]         cap_we;
    logic                             accept;
    logic                             last_byte;
    logic                             known;
    t_kind                            kind;

    assign o_ready   = ~i_q_full;
    assign accept    = i_valid & o_ready;
    assign last_byte = ({1'b0, r_pos} + 17'd1) >= {1'b0, r_len};

    for (genvar g = 0; g < CAPTURE_BYTES; g++) begin : g_cap
        assign cap_we[g]   = accept && (r_phase == PH_BODY) &&
                             (r_pos == FIRST_CAPTURED + 16'(g));
        assign cap_next[g] = cap_we[g] ? i_rx_byte : r_cap[g];

        always_ff @(posedge i_clk) begin
            if (cap_we[g]) begin
                r_cap[g] <= i_rx_byte;
            end
        end
    end

    for (genvar j = 0; j < REC_BYTES; j++) begin : g_rec
        assign o_rec.bytes[j] = cap_next[j];
    end

    always_comb begin
        known = 1'b0;
        kind  = KIND_SELFCHECK;
        if (r_type == TYPE_SELFCHECK && r_len >= LEN_SELFCHECK) begin
            known = 1'b1;
            kind  = KIND_SELFCHECK;
        end else if (r_type == TYPE_PULSE && r_len >= LEN_PULSE) begin
            known = 1'b1;
            kind  = KIND_PULSE;
        end else if (r_type == TYPE_BEAM && r_len >= LEN_BEAM) begin
            known = 1'b1;
            kind  = KIND_BEAM;
        end
    end

    assign o_rec.kind = kind;
    assign o_push     = accept && (r_phase == PH_BODY) && last_byte &&
                        (i_rx_byte == r_xor) && known;

    always_comb begin
        n_phase = r_phase;
        n_type  = r_type;
        n_len   = r_len;
        n_pos   = r_pos;
        n_xor   = r_xor;
        if (accept) begin
            case (r_phase)
                PH_HUNT2: begin
                    n_phase = (i_rx_byte == SYNC_BYTE) ? PH_TYPE : PH_HUNT1;
                end
                PH_TYPE: begin
                    n_type  = i_rx_byte;
                    n_xor   = i_rx_byte;
                    n_phase = PH_LEN_LO;
                end
                PH_LEN_LO: begin
                    n_len   = {8'h00, i_rx_byte};
                    n_xor   = r_xor ^ i_rx_byte;
                    n_phase = PH_LEN_HI;
                end
                PH_LEN_HI: begin
                    n_len = {i_rx_byte, r_len[7:0]};
                    n_xor = r_xor ^ i_rx_byte;
                    if ({i_rx_byte, r_len[7:0]} < MIN_LENGTH) begin
                        n_phase = PH_HUNT1;
                    end else begin
                        n_pos   = FIRST_CAPTURED;
                        n_phase = PH_BODY;
                    end
                end
                PH_BODY: begin
                    if (last_byte) begin
                        n_phase = PH_HUNT1;
                    end else begin
                        n_xor = r_xor ^ i_rx_byte;
                        n_pos = r_pos + 16'd1;
                    end
                end
                default: begin
                    n_phase = (i_rx_byte == SYNC_BYTE) ? PH_HUNT2 : PH_HUNT1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT1;
            r_type  <= 8'h00;
            r_len   <= 16'h0000;
            r_pos   <= 16'h0000;
            r_xor   <= 8'h00;
        end else begin
            r_phase <= n_phase;
            r_type  <= n_type;
            r_len   <= n_len;
            r_pos   <= n_pos;
            r_xor   <= n_xor;
        end
    end

endmodule
`default_nettype wire

### rtl/core/slxfp_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// slxfp_queue
// Two-entry record queue between the parser and the result formatter.
// ----------------------------------------------------------------------------
module slxfp_queue
    import slxfp_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_rec i_rec,
    output logic      o_full,
    input  wire logic i_pop,
    output logic      o_empty,
    output t_rec      o_rec
);

    t_rec       r_mem [2];
    logic       r_wr_ptr, r_rd_ptr;
    logic [1:0] r_count, n_count;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_rec   = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + 2'd1;
            2'b01:   n_count = r_count - 2'd1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= n_count;
        end
    end

endmodule
`default_nettype wire

### rtl/core/slxfp_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// slxfp_back
// Result formatter: decodes a queued record into the result fields and
// holds them in the output register.
// ----------------------------------------------------------------------------
module slxfp_back
    import slxfp_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_q_empty,
    input  wire t_rec  i_rec,
    output logic       o_pop,
    output logic       o_valid,
    input  wire logic  i_ready,
    output logic [1:0]  o_frame_kind,
    output logic [7:0]  o_status_first,
    output logic [7:0]  o_status_second,
    output logic [7:0]  o_status_third,
    output logic        o_chan_one_active,
    output logic        o_chan_two_active,
    output logic        o_chan_three_active,
    output logic [15:0] o_pulse_parameter,
    output logic [7:0]  o_pulse_channel_byte,
    output logic [7:0]  o_peak_frequency,
    output logic [31:0] o_beam_params_low,
    output logic [15:0] o_beam_param_third
);

    logic        r_valid;
    logic [1:0]  r_kind, n_kind;
    logic [7:0]  r_st1, n_st1, r_st2, n_st2, r_st3, n_st3;
    logic        r_f1, n_f1, r_f2, n_f2, r_f3, n_f3;
    logic [15:0] r_pparam, n_pparam;
    logic [7:0]  r_pchan, n_pchan;
    logic [7:0]  r_peak, n_peak;
    logic [31:0] r_blow, n_blow;
    logic [15:0] r_b3, n_b3;
    logic        flag1, flag2, flag3;

    assign o_pop = ~i_q_empty & (~r_valid | i_ready);

    assign flag1 = (i_rec.bytes[0][7:6] == FLAG_CHAN_ONE);
    assign flag2 = (i_rec.bytes[0][5:4] == FLAG_CHAN_TWO);
    assign flag3 = (i_rec.bytes[0][3:2] == FLAG_CHAN_THR);

    always_comb begin
        n_kind   = i_rec.kind;
        n_st1    = 8'h00;
        n_st2    = 8'h00;
        n_st3    = 8'h00;
        n_f1     = 1'b0;
        n_f2     = 1'b0;
        n_f3     = 1'b0;
        n_pparam = 16'h0000;
        n_pchan  = 8'h00;
        n_peak   = 8'h00;
        n_blow   = 32'h0000_0000;
        n_b3     = 16'h0000;
        case (i_rec.kind)
            KIND_SELFCHECK: begin
                n_st1 = i_rec.bytes[0];
                n_st2 = i_rec.bytes[1];
                n_st3 = i_rec.bytes[2];
            end
            KIND_PULSE: begin
                n_f1     = flag1;
                n_f2     = flag2;
                n_f3     = flag3;
                n_pparam = {i_rec.bytes[1], i_rec.bytes[2]};
                n_pchan  = i_rec.bytes[3];
            end
            KIND_BEAM: begin
                n_f1   = flag1;
                n_f2   = flag2;
                n_f3   = flag3;
                n_peak = i_rec.bytes[1];
                n_blow = {i_rec.bytes[2], i_rec.bytes[3],
                          i_rec.bytes[4], i_rec.bytes[5]};
                n_b3   = {i_rec.bytes[6], i_rec.bytes[7]};
            end
            default: begin
                n_kind = i_rec.kind;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_kind   <= n_kind;
            r_st1    <= n_st1;
            r_st2    <= n_st2;
            r_st3    <= n_st3;
            r_f1     <= n_f1;
            r_f2     <= n_f2;
            r_f3     <= n_f3;
            r_pparam <= n_pparam;
            r_pchan  <= n_pchan;
            r_peak   <= n_peak;
            r_blow   <= n_blow;
            r_b3     <= n_b3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    assign o_valid              = r_valid;
    assign o_frame_kind         = r_kind;
    assign o_status_first       = r_st1;
    assign o_status_second      = r_st2;
    assign o_status_third       = r_st3;
    assign o_chan_one_active    = r_f1;
    assign o_chan_two_active    = r_f2;
    assign o_chan_three_active  = r_f3;
    assign o_pulse_parameter    = r_pparam;
    assign o_pulse_channel_byte = r_pchan;
    assign o_peak_frequency     = r_peak;
    assign o_beam_params_low    = r_blow;
    assign o_beam_param_third   = r_b3;

endmodule
`default_nettype wire

### tb/sync_length_xor_frame_parser_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sync_length_xor_frame_parser_test
// Feeds the parser a byte stream: a few hand-built frames first, then
// random well-formed frames of each kind mixed with noise, broken sync, bad
// checksums, unknown types and short lengths. The byte-level decode is
// predicted in the testbench, and each result is checked field by field
// under three sender/receiver stall mixes.
// ----------------------------------------------------------------------------
module sync_length_xor_frame_parser_test
    import slxfp_pkg::*;
();

    localparam int CAPTURE_DEPTH = 10;

    typedef enum logic [5:0] {
        HUNT_FIRST  = 6'b000001,
        HUNT_SECOND = 6'b000010,
        GET_TYPE    = 6'b000100,
        GET_LEN_LO  = 6'b001000,
        GET_LEN_HI  = 6'b010000,
        GET_BODY    = 6'b100000
    } t_parse_phase;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  st_first;
        logic [7:0]  st_second;
        logic [7:0]  st_third;
        logic        chan_one;
        logic        chan_two;
        logic        chan_three;
        logic [15:0] pulse_par;
        logic [7:0]  pulse_chan;
        logic [7:0]  peak_freq;
        logic [31:0] beam_low;
        logic [15:0] beam_third;
    } t_frame_result;

    class t_frame_scoreboard;
        t_parse_phase  phase;
        logic [7:0]    ftype;
        logic [15:0]   flen;
        logic [15:0]   pos;
        logic [7:0]    xsum;
        logic [7:0]    captured [CAPTURE_DEPTH];
        t_frame_result expected_q [$];
        int            errors;
        int            bytes_seen;
        int            decoded [3];

        function new();
            phase      = HUNT_FIRST;
            ftype      = '0;
            flen       = '0;
            pos        = '0;
            xsum       = '0;
            errors     = 0;
            bytes_seen = 0;
            foreach (captured[i]) captured[i] = '0;
            foreach (decoded[i]) decoded[i] = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void decode_frame();
            t_frame_result r;
            r = '0;
            if (ftype == TYPE_SELFCHECK && flen >= LEN_SELFCHECK) begin
                r.kind      = KIND_SELFCHECK;
                r.st_first  = captured[0];
                r.st_second = captured[1];
                r.st_third  = captured[2];
                expected_q.push_back(r);
            end else if ((ftype == TYPE_PULSE && flen >= LEN_PULSE) ||
                         (ftype == TYPE_BEAM && flen >= LEN_BEAM)) begin
                r.chan_one   = (captured[0][7:6] == FLAG_CHAN_ONE);
                r.chan_two   = (captured[0][5:4] == FLAG_CHAN_TWO);
                r.chan_three = (captured[0][3:2] == FLAG_CHAN_THR);
                if (ftype == TYPE_PULSE) begin
                    r.kind       = KIND_PULSE;
                    r.pulse_par  = {captured[1], captured[2]};
                    r.pulse_chan = captured[3];
                end else begin
                    r.kind       = KIND_BEAM;
                    r.peak_freq  = captured[1];
                    r.beam_low   = {captured[2], captured[3], captured[4], captured[5]};
                    r.beam_third = {captured[6], captured[7]};
                end
                expected_q.push_back(r);
            end
        endfunction

        function void note_byte(logic [7:0] b);
            bytes_seen++;
            case (phase)
                HUNT_SECOND: phase = (b == SYNC_BYTE) ? GET_TYPE : HUNT_FIRST;
                GET_TYPE: begin
                    ftype = b;
                    xsum  = b;
                    phase = GET_LEN_LO;
                end
                GET_LEN_LO: begin
                    flen  = {8'h00, b};
                    xsum ^= b;
                    phase = GET_LEN_HI;
                end
                GET_LEN_HI: begin
                    flen[15:8] = b;
                    xsum      ^= b;
                    if (flen < MIN_LENGTH) begin
                        phase = HUNT_FIRST;
                    end else begin
                        pos   = FIRST_CAPTURED;
                        phase = GET_BODY;
                    end
                end
                GET_BODY: begin
                    if (int'(pos - FIRST_CAPTURED) < CAPTURE_DEPTH)
                        captured[4'(pos - FIRST_CAPTURED)] = b;
                    if ({1'b0, pos} + 17'd1 >= {1'b0, flen}) begin
                        if (b == xsum) decode_frame();
                        phase = HUNT_FIRST;
                    end else begin
                        xsum ^= b;
                        pos   = pos + 16'd1;
                    end
                end
                default: phase = (b == SYNC_BYTE) ? HUNT_SECOND : HUNT_FIRST;
            endcase
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $display("%0t: %s mismatch, expected %0h, actual %0h",
                         $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(t_frame_result got);
            t_frame_result want;
            if (expected_q.size() == 0) begin
                $display("%0t: result with none expected, kind %0d", $time, got.kind);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            decoded[int'(want.kind)]++;
            compare_field("frame_kind", want.kind, got.kind);
            compare_field("status_first", want.st_first, got.st_first);
            compare_field("status_second", want.st_second, got.st_second);
            compare_field("status_third", want.st_third, got.st_third);
            compare_field("chan_one_active", want.chan_one, got.chan_one);
            compare_field("chan_two_active", want.chan_two, got.chan_two);
            compare_field("chan_three_active", want.chan_three, got.chan_three);
            compare_field("pulse_parameter", want.pulse_par, got.pulse_par);
            compare_field("pulse_channel_byte", want.pulse_chan, got.pulse_chan);
            compare_field("peak_frequency", want.peak_freq, got.peak_freq);
            compare_field("beam_params_low", want.beam_low, got.beam_low);
            compare_field("beam_param_third", want.beam_third, got.beam_third);
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n   = 1'b0;
    logic        i_valid   = 1'b0;
    logic [7:0]  i_rx_byte = 8'h00;
    logic        i_ready   = 1'b0;
    logic        o_ready;
    logic        o_valid;
    logic [1:0]  o_frame_kind;
    logic [7:0]  o_status_first;
    logic [7:0]  o_status_second;
    logic [7:0]  o_status_third;
    logic        o_chan_one_active;
    logic        o_chan_two_active;
    logic        o_chan_three_active;
    logic [15:0] o_pulse_parameter;
    logic [7:0]  o_pulse_channel_byte;
    logic [7:0]  o_peak_frequency;
    logic [31:0] o_beam_params_low;
    logic [15:0] o_beam_param_third;

    t_frame_scoreboard sb;
    t_frame_result     seen_result;
    logic [7:0]        frame_q [$];
    int                tx_idle_pct = 0;
    int                rx_idle_pct = 0;
    int                bytes_sent  = 0;

    sync_length_xor_frame_parser #(
        .CAPTURE_BYTES(CAPTURE_DEPTH)
    ) DUT (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_ready             (o_ready),
        .i_rx_byte           (i_rx_byte),
        .o_valid             (o_valid),
        .i_ready             (i_ready),
        .o_frame_kind        (o_frame_kind),
        .o_status_first      (o_status_first),
        .o_status_second     (o_status_second),
        .o_status_third      (o_status_third),
        .o_chan_one_active   (o_chan_one_active),
        .o_chan_two_active   (o_chan_two_active),
        .o_chan_three_active (o_chan_three_active),
        .o_pulse_parameter   (o_pulse_parameter),
        .o_pulse_channel_byte(o_pulse_channel_byte),
        .o_peak_frequency    (o_peak_frequency),
        .o_beam_params_low   (o_beam_params_low),
        .o_beam_param_third  (o_beam_param_third)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // results are checked before the byte of the same edge is noted
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            seen_result.kind       = t_kind'(o_frame_kind);
            seen_result.st_first   = o_status_first;
            seen_result.st_second  = o_status_second;
            seen_result.st_third   = o_status_third;
            seen_result.chan_one   = o_chan_one_active;
            seen_result.chan_two   = o_chan_two_active;
            seen_result.chan_three = o_chan_three_active;
            seen_result.pulse_par  = o_pulse_parameter;
            seen_result.pulse_chan = o_pulse_channel_byte;
            seen_result.peak_freq  = o_peak_frequency;
            seen_result.beam_low   = o_beam_params_low;
            seen_result.beam_third = o_beam_param_third;
            sb.check_result(seen_result);
        end
        if (i_rst_n && i_valid && o_ready)
            sb.note_byte(i_rx_byte);
    end

    task automatic send_byte(input logic [7:0] value);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_rx_byte <= value;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        bytes_sent++;
    endtask

    task automatic send_frame();
        foreach (frame_q[i]) send_byte(frame_q[i]);
    endtask

    task automatic build_frame(input logic [7:0] ftype, input int len, input bit corrupt);
        logic [7:0] xsum;
        logic [7:0] b;
        xsum = ftype ^ len[7:0] ^ len[15:8];
        frame_q = '{SYNC_BYTE, SYNC_BYTE, ftype, len[7:0], len[15:8]};
        for (int i = 5; i < len - 1; i++) begin
            b = 8'($urandom);
            frame_q.push_back(b);
            xsum ^= b;
        end
        if (corrupt) xsum ^= 8'($urandom_range(1, 255));
        frame_q.push_back(xsum);
    endtask

    task automatic wait_for_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // noise never holds two F0 in a row and ends on a non-F0 byte,
    // so the parser is back to hunting afterwards
    task automatic random_frame();
        int         pick;
        int         sel;
        int         min_len;
        int         n;
        logic [7:0] ftype;
        logic [7:0] b;
        pick    = $urandom_range(99);
        sel     = $urandom_range(2);
        ftype   = (sel == 0) ? TYPE_SELFCHECK : (sel == 1) ? TYPE_PULSE : TYPE_BEAM;
        min_len = (sel == 0) ? int'(LEN_SELFCHECK) :
                  (sel == 1) ? int'(LEN_PULSE) : int'(LEN_BEAM);
        if (pick < 70) begin
            if ($urandom_range(9) == 0)
                build_frame(ftype, $urandom_range(min_len, 40), 1'b0);
            else
                build_frame(ftype, min_len + $urandom_range(4), 1'b0);
        end else if (pick < 75) begin
            frame_q.delete();
            n = $urandom_range(1, 6);
            for (int i = 0; i < n; i++) begin
                if (i < n - 1 && (i == 0 || frame_q[i-1] != SYNC_BYTE) &&
                    $urandom_range(3) == 0) begin
                    b = SYNC_BYTE;
                end else begin
                    b = 8'($urandom);
                    if (b == SYNC_BYTE) b = 8'h0F;
                end
                frame_q.push_back(b);
            end
        end else if (pick < 80) begin
            b = 8'($urandom);
            if (b == SYNC_BYTE) b = 8'hF1;
            frame_q = '{SYNC_BYTE, b};
        end else if (pick < 86) begin
            build_frame(ftype, min_len + $urandom_range(4), 1'b1);
        end else if (pick < 91) begin
            build_frame(8'($urandom), $urandom_range(6, 20), 1'b0);
        end else if (pick < 95) begin
            frame_q = '{SYNC_BYTE, SYNC_BYTE, 8'($urandom),
                        8'($urandom_range(0, 5)), 8'h00};
        end else begin
            build_frame(ftype, $urandom_range(6, min_len - 1), 1'b0);
        end
        send_frame();
    endtask

    initial begin
        sb = new();
        tx_idle_pct = 15;
        rx_idle_pct = 49;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // broken sync, short length, self-check with checksum as last status,
        // beam warning at its minimum length
        frame_q = '{SYNC_BYTE, 8'h55};
        send_frame();
        frame_q = '{SYNC_BYTE, SYNC_BYTE, TYPE_SELFCHECK, 8'h05, 8'h00};
        send_frame();
        frame_q = '{SYNC_BYTE, SYNC_BYTE, TYPE_SELFCHECK, 8'h08, 8'h00,
                    8'hFF, 8'h00, 8'hF5};
        send_frame();
        build_frame(TYPE_BEAM, 13, 1'b0);
        send_frame();
        wait_for_results();

        // one frame with a nonzero length high byte
        build_frame(TYPE_BEAM, 16'h0105, 1'b0);
        send_frame();

        for (int mode = 0; mode < 3; mode++) begin
            tx_idle_pct = (mode == 0) ? 15 : (mode == 1) ? 49 : 0;
            rx_idle_pct = (mode == 0) ? 49 : (mode == 1) ? 15 : 0;
            while (bytes_sent < 300 + 150 * (mode + 1)) random_frame();
            wait_for_results();
        end

        $display("Sent %0d bytes; decoded %0d self-check, %0d pulse, %0d beam frames",
                 sb.bytes_seen, sb.decoded[0], sb.decoded[1], sb.decoded[2]);
        $display("Stall mixes: sender-heavy, receiver-heavy and none; %0d mismatches",
                 sb.errors);
        if (sb.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

### files.f
rtl/core/slxfp_pkg.sv
rtl/core/slxfp_front.sv
rtl/core/slxfp_queue.sv
rtl/core/slxfp_back.sv
rtl/core/sync_length_xor_frame_parser.sv
tb/sync_length_xor_frame_parser_test.sv
